### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

### rtl/core/nfg_pkg.sv
// Shared constants, types and helper functions of the n-order Fibonacci generator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package nfg_pkg;

   localparam int MAX_ORDER   = 64;
   localparam int PTR_W       = $clog2(MAX_ORDER);
   localparam int ORDER_W     = 7;
   localparam int COUNT_W     = 7;
   localparam int MAX_TERMS   = 64;
   localparam int VALUE_W     = 64;
   localparam int INDEX_W     = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = VALUE_W + INDEX_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);
   localparam logic [INDEX_W-1:0] INDEX_MAX   = {INDEX_W{1'b1}};

   // One request as it travels from the front part to the engine.
   typedef struct packed {
      logic               restart;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SUM
   } state_type;

   // Engine status, watched by the checks in the top level.
   typedef struct packed {
      state_type state;
      logic      fire;
      logic      last;
   } stat_type;

   // Order zero behaves as order one; anything above the ring depth as the depth.
   function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] raw);
      logic [ORDER_W-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = ORDER_W'(1);
      end else if (raw > ORDER_W'(MAX_ORDER)) begin
         n = ORDER_W'(MAX_ORDER);
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] raw);
      logic [COUNT_W-1:0] c;
      c = raw;
      if (raw > COUNT_W'(MAX_TERMS)) begin
         c = COUNT_W'(MAX_TERMS);
      end
      return c;
   endfunction

endpackage

### rtl/core/nfg_front.sv
// Front part: accepts requests, saturates the count and drops requests that do nothing.
// Depends on nfg_pkg.
`timescale 1ns / 1ps

module nfg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [nfg_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   output logic                                push_valid,
   input  logic                                push_ready,
   output nfg_pkg::cmd_type                    push_cmd
);

   logic             hold_valid_ff, hold_valid_in;
   nfg_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   logic             accept;
   logic             keep;
   nfg_pkg::cmd_type cmd_new;

   always_comb begin
      cmd_new.restart = req_tuser;
      cmd_new.count   = nfg_pkg::sat_count(req_tdata[nfg_pkg::COUNT_W-1:0]);
      // A request without restart and without terms has no effect at all.
      keep          = cmd_new.restart || (cmd_new.count != '0);
      req_tready    = !hold_valid_ff || push_ready;
      accept        = req_tvalid && req_tready;
      hold_cmd_in   = accept ? cmd_new : hold_cmd_ff;
      if (accept) begin
         hold_valid_in = keep;
      end else begin
         hold_valid_in = hold_valid_ff && !push_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

endmodule

### rtl/core/nfg_cmd_queue.sv
// Short request queue between the front part and the engine.
// Depends on nfg_pkg.
`timescale 1ns / 1ps

module nfg_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  nfg_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output nfg_pkg::cmd_type pop_cmd
);

   nfg_pkg::cmd_type                entry_ff [nfg_pkg::QUEUE_DEPTH];
   logic [nfg_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [nfg_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [nfg_pkg::QPTR_W:0]        fill_ff, fill_in;
   logic                            push;
   logic                            pop;

   always_comb begin
      push_ready = (fill_ff != (nfg_pkg::QPTR_W+1)'(nfg_pkg::QUEUE_DEPTH));
      pop_valid  = (fill_ff != '0);
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in    = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
      pop_cmd = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/nfg_engine.sv
// Back part: keeps the term ring, the running window sum and the order register,
// and emits one term per cycle to the output register when not stalled. Depends on nfg_pkg.
`timescale 1ns / 1ps

module nfg_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [nfg_pkg::ORDER_W-1:0]       csr_wdata,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  nfg_pkg::cmd_type                  cmd,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nfg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   output nfg_pkg::stat_type                 stat
);

   localparam int PW = nfg_pkg::PTR_W;
   localparam int VW = nfg_pkg::VALUE_W;
   localparam int IW = nfg_pkg::INDEX_W;
   localparam int OW = nfg_pkg::ORDER_W;
   localparam int CW = nfg_pkg::COUNT_W;

   nfg_pkg::state_type state_ff, state_in;

   logic [OW-1:0]                   order_ff, order_in;
   logic [PW-1:0]                   wp_ff, wp_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [VW-1:0]                   sum_ff, sum_in;
   logic [nfg_pkg::MAX_ORDER-1:0]   valid_ff, valid_in;
   logic [CW-1:0]                   rem_ff, rem_in;
   logic [OW-1:0]                   k_ff, k_in;
   logic [VW-1:0]                   acc_ff, acc_in;
   logic                            pend_ff, pend_in;

   // Ring memory and its registered read port.
   logic [VW-1:0]                   ring [nfg_pkg::MAX_ORDER];
   logic [VW-1:0]                   rd_ff;
   logic                            vld_rd_ff, vld_rd_in;
   logic                            hit_ff, hit_in;
   logic [VW-1:0]                   byp_ff;
   logic [PW-1:0]                   rd_addr;

   logic                            out_valid_ff, out_valid_in;
   logic [VW-1:0]                   out_value_ff;
   logic [IW-1:0]                   out_index_ff;
   logic                            out_last_ff;

   logic [OW-1:0]                   n;
   logic [VW-1:0]                   leave;
   logic [VW-1:0]                   term_v;
   logic                            out_free;
   logic                            fire;
   logic                            last;
   logic                            pop;
   logic                            clear;
   logic                            issue;
   logic                            sum_done;

   always_comb begin
      n        = nfg_pkg::eff_order(order_ff);
      leave    = hit_ff ? byp_ff : (vld_rd_ff ? rd_ff : '0);
      if (idx_ff == '0) begin
         term_v = '0;
      end else if (idx_ff == IW'(1)) begin
         term_v = VW'(1);
      end else begin
         term_v = sum_ff;
      end
      out_free = !out_valid_ff || rsp_tready;
      fire     = (state_ff == nfg_pkg::ST_RUN) && out_free && !csr_we;
      last     = (rem_ff == CW'(1));
      pop      = (state_ff == nfg_pkg::ST_IDLE) && cmd_valid && !csr_we;
      clear    = pop && cmd.restart;
      issue    = (state_ff == nfg_pkg::ST_SUM) && (k_ff <= n);
      sum_done = (state_ff == nfg_pkg::ST_SUM) && !issue && !pend_ff && !csr_we;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = nfg_pkg::ST_SUM;
      end else begin
         unique case (state_ff)
            nfg_pkg::ST_IDLE: begin
               if (pop && (cmd.count != '0)) begin
                  state_in = nfg_pkg::ST_RUN;
               end
            end
            nfg_pkg::ST_RUN: begin
               if (fire && last) begin
                  state_in = nfg_pkg::ST_IDLE;
               end
            end
            nfg_pkg::ST_SUM: begin
               if (sum_done) begin
                  state_in = nfg_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = nfg_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // Datapath and outputs.
   always_comb begin
      order_in = csr_we ? csr_wdata : order_ff;

      wp_in    = wp_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      if (clear) begin
         wp_in    = '0;
         idx_in   = '0;
         sum_in   = '0;
         valid_in = '0;
      end else if (fire) begin
         wp_in         = wp_ff + 1'b1;
         idx_in        = (idx_ff == nfg_pkg::INDEX_MAX) ? idx_ff : idx_ff + 1'b1;
         sum_in        = sum_ff + term_v - leave;
         valid_in[wp_ff] = 1'b1;
      end else if (sum_done) begin
         sum_in = acc_ff;
      end

      rem_in = rem_ff;
      if (pop) begin
         rem_in = cmd.count;
      end else if (fire) begin
         rem_in = rem_ff - 1'b1;
      end

      // The summing pass walks the ring backward from the newest term.
      k_in    = k_ff;
      acc_in  = acc_ff;
      pend_in = 1'b0;
      if (csr_we) begin
         k_in   = OW'(1);
         acc_in = '0;
      end else if (state_ff == nfg_pkg::ST_SUM) begin
         acc_in  = pend_ff ? acc_ff + leave : acc_ff;
         pend_in = issue;
         if (issue) begin
            k_in = k_ff + 1'b1;
         end
      end

      // Outside the summing pass the port always fetches the term that leaves
      // the window on the next step.
      if (issue && !csr_we) begin
         rd_addr = wp_ff - k_ff[PW-1:0];
      end else begin
         rd_addr = wp_in - n[PW-1:0];
      end
      hit_in    = fire && (rd_addr == wp_ff);
      vld_rd_in = clear ? 1'b0 : valid_ff[rd_addr];

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      cmd_ready  = pop;
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {out_index_ff, out_value_ff};
      rsp_tlast  = out_last_ff;
      stat.state = state_ff;
      stat.fire  = fire;
      stat.last  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfg_pkg::ST_IDLE;
         order_ff     <= nfg_pkg::ORDER_RESET;
         wp_ff        <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rem_ff       <= '0;
         k_ff         <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         vld_rd_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         wp_ff        <= wp_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         rem_ff       <= rem_in;
         k_ff         <= k_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         vld_rd_ff    <= vld_rd_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ring[wp_ff] <= term_v;
      end
      rd_ff  <= ring[rd_addr];
      byp_ff <= term_v;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_value_ff <= term_v;
         out_index_ff <= idx_ff;
         out_last_ff  <= last;
      end
   end

endmodule

### rtl/core/n_order_fibonacci_generator.sv
// Top level of the n-order Fibonacci generator: front part, request queue and engine.
// Depends on nfg_pkg, nfg_front, nfg_cmd_queue, nfg_engine and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Generates the Fibonacci sequence of order n (n-bonacci): term 0 is 0, term 1
// is 1, and each later term is the sum of the previous n terms, or of all
// previous terms while fewer than n exist. Values wrap modulo 2^64 and the
// reported index saturates at 65535. Each request transfer on the req_ channel
// asks for term_count further terms (0 to 127, counts above 64 act as 64),
// optionally restarting at term 0 first; every term leaves as one rsp_ transfer
// with its index, and the final term of a request carries tlast. A request with
// no terms and no restart has no effect. Once the engine picks up a request
// it emits one term per cycle while the response side does not stall and no
// order write comes in. That rate is set by the running window sum, which is
// updated once per term, and by the single-read-port term ring that supplies
// the term leaving the window. The front part and a two-deep request queue
// keep accepting while the engine works. Writing the order register (csr_we
// with the new order in csr_wdata) starts a pass over the ring that recomputes
// the window sum; requests wait in the queue meanwhile. Order zero acts as
// order one and orders above 64 act as 64. Write the order only while no
// request is outstanding.
module n_order_fibonacci_generator (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [nfg_pkg::REQ_DATA_W-1:0]      req_tdata,  // [6:0] term_count, [7] zero
   input  logic                                req_tuser,  // [0] restart
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [nfg_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [63:0] term_value, [79:64] term_index
   output logic                                rsp_tlast,  // last
   // Order register write port.
   input  logic                                csr_we,
   input  logic [nfg_pkg::ORDER_W-1:0]         csr_wdata   // order
);

   logic              push_valid;
   logic              push_ready;
   nfg_pkg::cmd_type  push_cmd;
   logic              cmd_valid;
   logic              cmd_ready;
   nfg_pkg::cmd_type  cmd;
   nfg_pkg::stat_type stat;

   // The front part saturates the count and filters out requests that do nothing.
   nfg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // The queue lets the front part take new requests while the engine is busy.
   nfg_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_cmd    (cmd)
   );

   // The engine owns the sequence state and the registered response stage.
   nfg_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .stat       (stat)
   );

   // A term that is not the last of its request keeps the engine generating.
   `ASSERT_NEXT(a_run_continues, clock, reset, stat.fire && !stat.last && !csr_we, stat.state == nfg_pkg::ST_RUN)

   // No term may be produced while the window sum is being rebuilt.
   `ASSERT_IMPLIES(a_no_term_in_sum, clock, reset, stat.state == nfg_pkg::ST_SUM, !stat.fire)

   // Term one of every sequence is one, whatever the order.
   `ASSERT_IMPLIES(a_term_one, clock, reset, rsp_tvalid && (rsp_tdata[79:64] == 16'd1), rsp_tdata[63:0] == 64'd1)

endmodule
